// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udf assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udf assertion failed");

`endif

// File: design/udf_pkg.sv
// types, constants and the crc step for the datagram framer
`timescale 1ns / 1ps
`default_nettype none

package udf_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'h05;
    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic       OP_WRITE       = 1'b0;
    localparam logic       OP_READ        = 1'b1;
    // index of the crc byte within a datagram
    localparam logic [2:0] LAST_IDX_WRITE = 3'd7;
    localparam logic [2:0] LAST_IDX_READ  = 3'd3;

    // one classified request: datagram bytes before the crc, and the crc position
    typedef struct packed {
        logic [2:0]      last_idx;
        logic [7:0][7:0] bytes;
    } t_entry;

    // handshake between the request queue and the byte sequencer
    typedef struct packed {
        logic valid;
    } t_q_status;

    typedef struct packed {
        logic pop;
    } t_q_ctrl;

    // crc8, polynomial 0x07, one byte fed lsb first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++) begin
            if (crc[7] ^ data[b]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// File: design/uart_datagram_framer_crc8.sv
// top level of the uart datagram framer with crc8
// a request is first written into the queue, then its first byte into the output register
// throughput: one byte per cycle while a request is queued and the receiver is ready,
// set by the single byte sequencer and its one output register
// a two-entry request queue lets new requests in while a datagram is still going out
// reset: synchronous active-low, clears the queue, the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none

module uart_datagram_framer_crc8 (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // node_address[7:0], register_address[15:8], write_data[47:16]
    input  wire         s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte[7:0]
    output logic        m_axis_tlast
);
    import udf_pkg::*;

    t_entry    q_entry;
    t_q_status q_status;
    t_q_ctrl   q_ctrl;

    udf_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (s_axis_tvalid),
        .o_ready            (s_axis_tready),
        .i_op               (s_axis_tuser),
        .i_node_address     (s_axis_tdata[7:0]),
        .i_register_address (s_axis_tdata[15:8]),
        .i_write_data       (s_axis_tdata[47:16]),
        .o_entry            (q_entry),
        .o_status           (q_status),
        .i_ctrl             (q_ctrl)
    );

    udf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (q_entry),
        .i_status     (q_status),
        .o_ctrl       (q_ctrl),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_frame_byte (m_axis_tdata),
        .o_last_byte  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: design/udf_front.sv
// request intake: classify a request into datagram bytes and queue it
`timescale 1ns / 1ps
`default_nettype none

module udf_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_op,
    input  wire  [7:0]         i_node_address,
    input  wire  [7:0]         i_register_address,
    input  wire  [31:0]        i_write_data,
    output udf_pkg::t_entry    o_entry,
    output udf_pkg::t_q_status o_status,
    input  udf_pkg::t_q_ctrl   i_ctrl
);
    import udf_pkg::*;

    t_entry     n_entry;
    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    // build the byte list of the datagram
    always_comb begin
        n_entry.bytes[0] = SYNC_BYTE;
        n_entry.bytes[1] = i_node_address;
        n_entry.bytes[2] = i_register_address;
        n_entry.bytes[3] = i_write_data[31:24];
        n_entry.bytes[4] = i_write_data[23:16];
        n_entry.bytes[5] = i_write_data[15:8];
        n_entry.bytes[6] = i_write_data[7:0];
        n_entry.bytes[7] = 8'h00;
        n_entry.last_idx = (i_op == OP_READ) ? LAST_IDX_READ : LAST_IDX_WRITE;
    end

    assign o_ready         = (r_count != 2'd2);
    assign push            = i_valid && o_ready;
    assign pop             = i_ctrl.pop;
    assign o_status.valid  = (r_count != 2'd0);
    assign o_entry         = r_mem[r_rd_ptr];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_entry;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// File: design/udf_back.sv
// byte sequencer: one datagram byte per cycle unless stalled, crc byte last
`timescale 1ns / 1ps
`default_nettype none

module udf_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  udf_pkg::t_entry    i_entry,
    input  udf_pkg::t_q_status i_status,
    output udf_pkg::t_q_ctrl   o_ctrl,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_byte
);
    import udf_pkg::*;

    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_last;
    logic       n_last;
    logic       advance;
    logic       at_crc;
    logic [7:0] cur_byte;

    assign advance  = i_status.valid && (!r_valid || i_ready);
    assign at_crc   = (r_idx == i_entry.last_idx);
    assign cur_byte = i_entry.bytes[r_idx];
    assign o_ctrl.pop = advance && at_crc;

    // next byte, crc and output register
    always_comb begin
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_byte  = r_byte;
        n_last  = r_last;
        n_valid = r_valid && !i_ready;
        if (advance) begin
            n_valid = 1'b1;
            if (at_crc) begin
                n_byte = r_crc;
                n_last = 1'b1;
                n_idx  = 3'd0;
                n_crc  = 8'h00;
            end else begin
                n_byte = cur_byte;
                n_last = 1'b0;
                n_idx  = r_idx + 3'd1;
                n_crc  = crc8_feed(r_crc, cur_byte);
            end
        end
    end

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_crc   <= 8'h00;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_crc   <= n_crc;
            r_valid <= n_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

endmodule

`default_nettype wire

// File: design/udf_checker.sv
// port-level checks on the framer output stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module udf_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire       m_axis_tlast
);
    import udf_pkg::*;

    logic       r_cnt_valid;
    logic [2:0] r_cnt;
    logic       xfer;

    assign xfer = m_axis_tvalid && m_axis_tready;

    // position of the next byte within its datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (xfer) begin
            r_cnt <= m_axis_tlast ? 3'd0 : r_cnt + 3'd1;
        end
    end

    assign r_cnt_valid = 1'b1;

    // a stalled byte is held
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // each datagram opens with the sync byte
    `ASSERT_SAME(a_sync, i_clk, i_rst_n, r_cnt_valid && xfer && r_cnt == 3'd0, m_axis_tdata == SYNC_BYTE && !m_axis_tlast)
    // the crc byte ends a read or a write datagram only
    `ASSERT_SAME(a_len, i_clk, i_rst_n, xfer && m_axis_tlast, r_cnt == LAST_IDX_READ || r_cnt == LAST_IDX_WRITE)
    // a write datagram never runs past eight bytes
    `ASSERT_SAME(a_max, i_clk, i_rst_n, xfer && r_cnt == LAST_IDX_WRITE, m_axis_tlast)

endmodule

bind uart_datagram_framer_crc8 udf_checker u_udf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: dv/uart_datagram_framer_crc8_tb.sv
// self-checking testbench for the uart datagram framer with crc8
`timescale 1ns / 1ps

module uart_datagram_framer_crc8_tb;

    import udf_pkg::*;

    localparam int NUM_DIRECTED   = 18;
    localparam int NUM_RANDOM     = 98;
    localparam int NUM_HOLDOFF    = 14;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 20;

    // one request, with a crc typed in where it is known by hand
    typedef struct packed {
        logic        op;
        logic [7:0]  node;
        logic [7:0]  regb;
        logic [31:0] data;
        logic        crc_known;
        logic [7:0]  crc_typed;
    } t_request_row;

    // one datagram byte as it leaves the block
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_datagram_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // node_address[7:0], register_address[15:8], write_data[47:16]
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // frame_byte[7:0]
    logic        m_axis_tlast;

    t_datagram_byte pending_bytes [$];
    t_datagram_byte oldest_byte;
    t_request_row   directed_rows [NUM_DIRECTED];
    int unsigned    mismatches = 0;
    bit             src_idle_on = 1'b1;
    bit             sink_idle_on = 1'b1;
    int unsigned    holdoffs_asked = 0;
    int unsigned    holdoffs_served = 0;
    int unsigned    sink_stall_left = 0;

    uart_datagram_framer_crc8 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // crc8 over one byte, polynomial 0x07, bits taken lsb first
    function automatic logic [7:0] crc8_absorb(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // expected datagram for one accepted request, appended to the byte queue
    task automatic queue_datagram(input t_request_row r);
        logic [7:0]     seq [8];
        logic [7:0]     crc;
        int             len;
        t_datagram_byte db;
        seq[0] = SYNC_BYTE;
        seq[1] = r.node;
        seq[2] = r.regb;
        {seq[3], seq[4], seq[5], seq[6]} = r.data;
        seq[7] = 8'h00;
        len = (r.op == OP_READ) ? 4 : 8;
        crc = 8'h00;
        for (int k = 0; k < len - 1; k++) crc = crc8_absorb(crc, seq[k]);
        seq[len-1] = r.crc_known ? r.crc_typed : crc;
        for (int k = 0; k < len; k++) begin
            db.frame_byte = seq[k];
            db.last_byte  = (k == len - 1);
            pending_bytes.push_back(db);
        end
    endtask

    function automatic t_request_row random_request();
        t_request_row r;
        r.op        = $urandom_range(1) ? OP_READ : OP_WRITE;
        r.node      = 8'($urandom_range(255));
        r.regb      = 8'($urandom_range(255));
        r.data      = $urandom();
        r.crc_known = 1'b0;
        r.crc_typed = 8'h00;
        return r;
    endfunction

    // offer one request from a falling edge, return at the falling edge after its transfer
    task automatic offer_request(input t_request_row r);
        while (src_idle_on && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom(), 16'($urandom())};
            s_axis_tuser  <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.data, r.regb, r.node};
        s_axis_tuser  <= r.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        queue_datagram(r);
        @(negedge i_clk);
    endtask

    // sender stops until every outstanding byte has come out
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
    endtask

    // receiver side: random stalls, steady stretches and requested hold-offs
    always @(negedge i_clk) begin
        if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_axis_tready   <= 1'b0;
        end else if (holdoffs_served != holdoffs_asked) begin
            holdoffs_served <= holdoffs_served + 1;
            sink_stall_left <= HOLDOFF_CYCLES - 1;
            m_axis_tready   <= 1'b0;
        end else if (sink_idle_on) begin
            m_axis_tready <= ($urandom_range(99) >= 31);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each output transfer with the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected output transfer: frame_byte %h last_byte %b",
                       m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                oldest_byte = pending_bytes.pop_front();
                if (m_axis_tdata !== oldest_byte.frame_byte) begin
                    $error("frame_byte mismatch: expected %h, actual %h",
                           oldest_byte.frame_byte, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== oldest_byte.last_byte) begin
                    $error("last_byte mismatch: expected %b, actual %b",
                           oldest_byte.last_byte, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus sequence
    initial begin
        // op, node, register, data, crc known, crc
        directed_rows = '{
            '{OP_READ,  8'h00, 8'h00, 32'h0000_0000, 1'b1, 8'h48},
            '{OP_WRITE, 8'h00, 8'h00, 32'h0000_0000, 1'b0, 8'h00},
            '{OP_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
            '{OP_READ,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
            '{OP_READ,  8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00},
            '{OP_WRITE, 8'h05, 8'h05, 32'h0505_0505, 1'b0, 8'h00},
            '{OP_WRITE, 8'h55, 8'hAA, 32'h55AA_55AA, 1'b0, 8'h00},
            '{OP_WRITE, 8'hAA, 8'h55, 32'hAA55_AA55, 1'b0, 8'h00},
            '{OP_READ,  8'h01, 8'h80, 32'h0000_0000, 1'b0, 8'h00},
            '{OP_READ,  8'h80, 8'h01, 32'h0000_0000, 1'b0, 8'h00},
            '{OP_WRITE, 8'h01, 8'h80, 32'h8000_0001, 1'b0, 8'h00},
            '{OP_WRITE, 8'h7F, 8'hFE, 32'h0123_4567, 1'b0, 8'h00},
            '{OP_WRITE, 8'h00, 8'h00, 32'h0000_0001, 1'b0, 8'h00},
            '{OP_WRITE, 8'h00, 8'h00, 32'h8000_0000, 1'b0, 8'h00},
            '{OP_WRITE, 8'h12, 8'hA3, 32'hDEAD_BEEF, 1'b0, 8'h00},
            '{OP_READ,  8'hC3, 8'h3C, 32'h1234_5678, 1'b0, 8'h00},
            '{OP_WRITE, 8'hFE, 8'h7F, 32'hFFFF_0000, 1'b0, 8'h00},
            '{OP_WRITE, 8'h00, 8'hFF, 32'h0000_FFFF, 1'b0, 8'h00}
        };

        // hold reset, then release it
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int n = 0; n < NUM_DIRECTED; n++) offer_request(directed_rows[n]);
        wait_until_drained();

        // receiver holds off while requests keep coming, so the input stalls
        src_idle_on = 1'b0;
        holdoffs_asked++;
        for (int n = 0; n < NUM_HOLDOFF; n++) offer_request(random_request());
        src_idle_on = 1'b1;

        // random requests, with one stretch free of idling on both sides
        for (int n = 0; n < NUM_RANDOM; n++) begin
            src_idle_on  = !(n >= 40 && n < 70);
            sink_idle_on = src_idle_on;
            if (n == 80) wait_until_drained();
            offer_request(random_request());
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        s_axis_tvalid <= 1'b0;

        // let the last datagrams out
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
